// ===== hw/rtl/lphs_pkg.sv =====
// lphs_pkg: shared types and constants for the linear probing hash set
// depends on nothing; imported by linear_probe_hash_set_core
package lphs_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = IDX_W + 1;
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int HASH_W    = 32;
  localparam int STEP_W    = 5;
  localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(53);
  localparam logic [HASH_W-1:0] HASH_MUL = HASH_W'(131);

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_TOMB  = 2'd1,
    MARK_USED  = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_DIV,
    S_READ,
    S_CHECK
  } state_t;

  localparam logic [2:0] REG_TABLE_SIZE = 3'd0;

endpackage

// ===== hw/rtl/linear_probe_hash_set_core.sv =====
// linear_probe_hash_set_core: hash set of short string keys, linear probing
// depends on lphs_pkg; holds the key memory and slot marks

// One operation at a time: the key bytes are hashed through one
// multiply-add, then the hash is reduced modulo table_size (clamped to
// 1..64) with a one bit per cycle restoring divider, then each slot
// visited is a slot mark and key read, then a compare, which waits while
// the output register is stalled. A word visits probes+1 slots, or probes
// slots when it runs through the whole table. in_stall is high from the
// accepted word until the result is loaded into the output register,
// which may still be waiting while the next word is accepted.
// table_size must be written only while idle; the block does not enforce
// it. Slot marks clear at reset.
module linear_probe_hash_set_core
  import lphs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [KEY_W-1:0]  key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [IDX_W-1:0]  slot,
  output logic [CNT_W-1:0]  probes,
  output logic [CNT_W-1:0]  deleted_seen,
  output logic [CNT_W-1:0]  count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  state_t             state, state_next;
  logic [1:0]         op, op_next;
  logic [KEY_W-1:0]   key_sh, key_sh_next;
  logic [KEY_W-1:0]   nkey, nkey_next;
  logic               stopped, stopped_next;
  logic [HASH_W-1:0]  hash_h, hash_h_next;
  logic [STEP_W-1:0]  step, step_next;
  logic [CNT_W-1:0]   rem, rem_next;
  logic [IDX_W-1:0]   pos, pos_next;
  logic [CNT_W-1:0]   probe_cnt, probe_cnt_next;
  logic [CNT_W-1:0]   tombs, tombs_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [CNT_W-1:0]   table_size;
  logic [CNT_W-1:0]   size_eff;
  logic               out_free;
  logic               load_out;
  logic [2:0]         res_status;
  logic [IDX_W-1:0]   res_slot;
  logic [CNT_W-1:0]   res_probes;
  logic               mem_we;
  logic               mark_we;
  logic [1:0]         mark_wdata;
  logic [1:0]         cur_mark;
  logic [KEY_W-1:0]   rd_key;
  logic [KEY_W-1:0]   key_mem [CAPACITY];
  logic [1:0]         slot_mark [CAPACITY];
  logic [7:0]         hbyte;
  logic               live;
  logic [CNT_W:0]     trial;
  logic [CNT_W-1:0]   p_inc;
  logic [IDX_W:0]     pos_inc;
  logic               key_eq;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE[0]);
  assign prdata = (paddr[2] == REG_TABLE_SIZE[0]) ? {{(32-CNT_W){1'b0}}, table_size} : 32'd0;

  always_comb begin
    if (table_size == '0) begin
      size_eff = CNT_W'(1);
    end else if (table_size > CNT_W'(CAPACITY)) begin
      size_eff = CNT_W'(CAPACITY);
    end else begin
      size_eff = table_size;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign key_eq   = (rd_key == nkey);

  always_comb begin
    state_next       = state;
    op_next          = op;
    key_sh_next      = key_sh;
    nkey_next        = nkey;
    stopped_next     = stopped;
    hash_h_next      = hash_h;
    step_next        = step;
    rem_next         = rem;
    pos_next         = pos;
    probe_cnt_next   = probe_cnt;
    tombs_next       = tombs;
    entry_count_next = entry_count;
    load_out         = 1'b0;
    res_status       = ST_NOT_FOUND;
    res_slot         = pos;
    res_probes       = probe_cnt;
    mem_we           = 1'b0;
    mark_we          = 1'b0;
    mark_wdata       = MARK_USED;
    hbyte            = key_sh[KEY_W-1 -: 8];
    live             = !stopped && (hbyte != 8'd0);
    trial            = {rem, hash_h[HASH_W-1]};
    p_inc            = probe_cnt + CNT_W'(1);
    pos_inc          = {1'b0, pos} + (IDX_W+1)'(1);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next      = kind;
          key_sh_next  = key;
          nkey_next    = '0;
          stopped_next = 1'b0;
          hash_h_next  = '0;
          step_next    = '0;
          state_next   = S_HASH;
        end
      end
      S_HASH: begin
        if (live) begin
          hash_h_next = hash_h * HASH_MUL + {24'd0, hbyte};
        end
        nkey_next    = {nkey[KEY_W-9:0], live ? hbyte : 8'd0};
        stopped_next = !live;
        key_sh_next  = {key_sh[KEY_W-9:0], 8'd0};
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(KEY_BYTES - 1)) begin
          step_next  = '0;
          rem_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, size_eff}) begin
          rem_next = CNT_W'(trial - {1'b0, size_eff});
        end else begin
          rem_next = trial[CNT_W-1:0];
        end
        hash_h_next = {hash_h[HASH_W-2:0], 1'b0};
        step_next   = step + STEP_W'(1);
        if (step == STEP_W'(HASH_W - 1)) begin
          pos_next       = rem_next[IDX_W-1:0];
          probe_cnt_next = '0;
          tombs_next     = '0;
          state_next     = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (out_free) begin
          if (op == KIND_INSERT) begin
            if (cur_mark != MARK_USED) begin
              mem_we           = 1'b1;
              mark_we          = 1'b1;
              mark_wdata       = MARK_USED;
              entry_count_next = entry_count + CNT_W'(1);
              res_status       = ST_INSERTED;
              load_out         = 1'b1;
            end else if (key_eq) begin
              res_status = ST_DUPLICATE;
              load_out   = 1'b1;
            end
          end else begin
            if (cur_mark == MARK_EMPTY) begin
              res_status = ST_NOT_FOUND;
              load_out   = 1'b1;
            end else if (cur_mark == MARK_USED && key_eq) begin
              if (op == KIND_REMOVE) begin
                mark_we    = 1'b1;
                mark_wdata = MARK_TOMB;
                if (entry_count != '0) begin
                  entry_count_next = entry_count - CNT_W'(1);
                end
                res_status = ST_REMOVED;
              end else begin
                res_status = ST_FOUND;
              end
              load_out = 1'b1;
            end else if (cur_mark == MARK_TOMB) begin
              tombs_next = tombs + CNT_W'(1);
            end
          end
          if (!load_out) begin
            // step to the next slot, or give up after size_eff slots
            probe_cnt_next = p_inc;
            if (p_inc == size_eff) begin
              res_status = (op == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
              res_probes = p_inc;
              load_out   = 1'b1;
            end else begin
              pos_next   = (CNT_W'(pos_inc) == size_eff) ? '0 : pos_inc[IDX_W-1:0];
              state_next = S_READ;
            end
          end
          if (load_out) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      table_size  <= SIZE_RESET;
      out_valid   <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_mark[i] <= MARK_EMPTY;
      end
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (cfg_we) begin
        table_size <= pwdata[CNT_W-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (mark_we) begin
        slot_mark[pos] <= mark_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    key_sh    <= key_sh_next;
    nkey      <= nkey_next;
    stopped   <= stopped_next;
    hash_h    <= hash_h_next;
    step      <= step_next;
    rem       <= rem_next;
    pos       <= pos_next;
    probe_cnt <= probe_cnt_next;
    tombs     <= tombs_next;
    if (load_out) begin
      status       <= res_status;
      slot         <= res_slot;
      probes       <= res_probes;
      deleted_seen <= (op == KIND_INSERT) ? '0 : tombs_next;
      count        <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[pos] <= nkey;
    end
    if (state == S_READ) begin
      rd_key   <= key_mem[pos];
      cur_mark <= slot_mark[pos];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_pos_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (CNT_W'(pos) < size_eff) && (probe_cnt < size_eff))
    else $error("probe outside table");

  a_result_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_CHECK))
    else $error("result loaded outside compare step");

  a_write_in_check: assert property (@(posedge clk) disable iff (rst)
    (mem_we || mark_we) |-> (state == S_CHECK) && load_out)
    else $error("table written without finishing a word");
`endif

endmodule
